@@ src/itoa_pkg.sv @@
package itoa_pkg;

  localparam int MAG_W      = 64;
  localparam int DIG_W      = 4;
  localparam int MAX_DIGITS = 20;
  localparam int BCD_W      = MAX_DIGITS * DIG_W;
  localparam int DIDX_W     = $clog2(MAX_DIGITS);
  localparam int SHIFT_W    = $clog2(MAG_W);

  localparam logic [DIDX_W-1:0]  DEC_TOP    = DIDX_W'(MAX_DIGITS - 1);
  localparam logic [DIDX_W-1:0]  HEX_TOP    = DIDX_W'(MAG_W / DIG_W - 1);
  localparam logic [SHIFT_W-1:0] SHIFT_LAST = SHIFT_W'(MAG_W - 1);

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  typedef struct packed {
    logic start;
    logic is_hex;
  } conv_ctrl_t;

  typedef struct packed {
    logic busy;
  } conv_stat_t;

  function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < DIG_W'(10)) begin
      digit_char = CH_ZERO + {4'b0, d};
    end else begin
      digit_char = base + {4'b0, d} - 8'd10;
    end
  endfunction

endpackage

@@ src/itoa_if.sv @@
interface itoa_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic               is_hex;
  logic               upper_case;
  logic               as_unsigned;
  logic [4:0]         pad_zeros;

  modport source (output valid, value, is_hex, upper_case, as_unsigned, pad_zeros,
                  input ready);
  modport sink (input valid, value, is_hex, upper_case, as_unsigned, pad_zeros,
                output ready);
endinterface

interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, ch, last, input ready);
  modport sink (input valid, ch, last, output ready);
endinterface

@@ src/itoa_dabble.sv @@
module itoa_dabble (
  input  logic                          clk,
  input  logic                          rst_n,
  input  itoa_pkg::conv_ctrl_t          ctrl,
  input  logic [itoa_pkg::MAG_W-1:0]    mag,
  input  logic [itoa_pkg::DIDX_W-1:0]   rd_idx,
  output itoa_pkg::conv_stat_t          stat,
  output logic [itoa_pkg::DIG_W-1:0]    rd_digit
);
  import itoa_pkg::*;

  logic [MAG_W-1:0]   mag_r;
  logic [BCD_W-1:0]   bcd_r;
  logic [BCD_W-1:0]   adj;
  logic               busy_r;
  logic [SHIFT_W-1:0] cnt_r;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_r[i*DIG_W +: DIG_W] >= DIG_W'(5)) begin
        adj[i*DIG_W +: DIG_W] = bcd_r[i*DIG_W +: DIG_W] + DIG_W'(3);
      end else begin
        adj[i*DIG_W +: DIG_W] = bcd_r[i*DIG_W +: DIG_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctrl.start) begin
      busy_r <= !ctrl.is_hex;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + SHIFT_W'(1);
      if (cnt_r == SHIFT_LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      mag_r <= mag;
      if (ctrl.is_hex) begin
        bcd_r <= BCD_W'(mag);
      end else begin
        bcd_r <= '0;
      end
    end else if (busy_r) begin
      bcd_r <= {adj[BCD_W-2:0], mag_r[MAG_W-1]};
      mag_r <= {mag_r[MAG_W-2:0], 1'b0};
    end
  end

  assign stat.busy = busy_r;
  assign rd_digit  = (rd_idx < DIDX_W'(MAX_DIGITS)) ? bcd_r[rd_idx*DIG_W +: DIG_W] : '0;

endmodule

@@ src/integer_to_ascii.sv @@
// Sequence: decimal runs the value through the add-3 shifter (64 shifts), then a
//   leading-zero scan finds the first digit to emit; hex skips the shifter and goes
//   straight to the scan.
// Throughput: one character per cycle once emitting, while out_chan.ready is high; the
//   next value is taken as soon as the last character sits in the output register.
// Reset: synchronous active-low rst_n returns to idle with the output register empty.
module integer_to_ascii #(
  parameter int MAX_PAD = 31
) (
  input logic         clk,
  input logic         rst_n,
  itoa_in_if.sink     in_chan,
  itoa_out_if.source  out_chan
);
  import itoa_pkg::*;

  localparam int PAD_W = $clog2(MAX_PAD + 2);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CONV  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_SIGN  = 6'b001000,
    S_PAD   = 6'b010000,
    S_DIGIT = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic              minus_r, minus_nxt;
  logic              upper_r, upper_nxt;
  logic              hex_r, hex_nxt;
  logic [PAD_W-1:0]  pad_r, pad_nxt;
  logic [DIDX_W-1:0] idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_ch_r, out_ch_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_fire;
  logic              out_free;
  logic              neg;
  logic [MAG_W-1:0]  raw;
  logic [MAG_W-1:0]  mag;
  logic [PAD_W-1:0]  pad_sat;
  logic [DIG_W-1:0]  rd_digit;
  conv_ctrl_t        conv_ctrl;
  conv_stat_t        conv_stat;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign raw = $unsigned(in_chan.value);
  assign neg = !in_chan.as_unsigned && raw[MAG_W-1];
  assign mag = neg ? (~raw + MAG_W'(1)) : raw;

  always_comb begin
    if (int'(in_chan.pad_zeros) > MAX_PAD) begin
      pad_sat = PAD_W'(MAX_PAD);
    end else begin
      pad_sat = PAD_W'(in_chan.pad_zeros);
    end
  end

  assign conv_ctrl.start  = in_fire;
  assign conv_ctrl.is_hex = in_chan.is_hex;

  itoa_dabble u_dabble (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (conv_ctrl),
    .mag      (mag),
    .rd_idx   (idx_r),
    .stat     (conv_stat),
    .rd_digit (rd_digit)
  );

  always_comb begin
    state_nxt     = state_r;
    minus_nxt     = minus_r;
    upper_nxt     = upper_r;
    hex_nxt       = hex_r;
    pad_nxt       = pad_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_ch_nxt    = out_ch_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          minus_nxt = neg;
          upper_nxt = in_chan.upper_case;
          hex_nxt   = in_chan.is_hex;
          pad_nxt   = pad_sat;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        if (!conv_stat.busy) begin
          idx_nxt   = hex_r ? HEX_TOP : DEC_TOP;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_digit == '0 && idx_r != '0) begin
          idx_nxt = idx_r - DIDX_W'(1);
        end else if (minus_r) begin
          state_nxt = S_SIGN;
        end else if (pad_r != '0) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_DIGIT;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = CH_MINUS;
          out_last_nxt  = 1'b0;
          minus_nxt     = 1'b0;
          state_nxt     = (pad_r != '0) ? S_PAD : S_DIGIT;
        end
      end
      S_PAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = CH_ZERO;
          out_last_nxt  = 1'b0;
          pad_nxt       = pad_r - PAD_W'(1);
          if (pad_r == PAD_W'(1)) begin
            state_nxt = S_DIGIT;
          end
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = digit_char(rd_digit, upper_r);
          out_last_nxt  = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r - DIDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      minus_r     <= 1'b0;
      pad_r       <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      minus_r     <= minus_nxt;
      pad_r       <= pad_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    upper_r    <= upper_nxt;
    hex_r      <= hex_nxt;
    out_ch_r   <= out_ch_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.ch    = out_ch_r;
  assign out_chan.last  = out_last_r;

endmodule

@@ src/itoa_checker.sv @@
module itoa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_ch,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ch) && $stable(out_last))
    else $error("output dropped or changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an input transfer");

  a_no_take_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("ready while a conversion is still emitting");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind integer_to_ascii itoa_checker u_itoa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_ch    (out_chan.ch),
  .out_last  (out_chan.last)
);
